@@ hw/rtl/smbhc_pkg.sv @@
// Shared types and constants for the SMB host classifier.
package smbhc_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int PROTO_W = 8;
  localparam int HOST_SLOTS_DEF = 8;

  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PORT_W-1:0] SMB_PORT_DIRECT = 16'd445;
  localparam logic [PORT_W-1:0] SMB_PORT_NETBIOS = 16'd139;
  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_INBOUND  = 2'd0,
    REQ_OUTBOUND = 2'd1,
    REQ_SET_HOST = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  typedef struct packed {
    logic              add;
    logic              purge;
    logic [ADDR_W-1:0] addr;
  } tbl_cmd_t;

  typedef struct packed {
    logic known;
    logic added;
  } tbl_stat_t;

endpackage

@@ hw/rtl/smbhc_host_table.sv @@
// Host address table with parallel lookup; an insert goes to the first slot that is free or already holds the address.
module smbhc_host_table
  import smbhc_pkg::*;
#(
  parameter int HOST_SLOTS = HOST_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_cmd_t          cmd,
  input  logic [ADDR_W-1:0] lookup_addr,
  output tbl_stat_t         stat
);

  logic [ADDR_W-1:0]     slot [HOST_SLOTS];
  logic [HOST_SLOTS-1:0] empty;
  logic [HOST_SLOTS-1:0] hit_lookup;
  logic [HOST_SLOTS-1:0] hit_cmd;
  logic [HOST_SLOTS-1:0] first_empty;
  logic [HOST_SLOTS-1:0] eligible;
  logic [HOST_SLOTS-1:0] free_or_hit;
  logic [HOST_SLOTS-1:0] wr_sel;

  always_comb begin
    for (int k = 0; k < HOST_SLOTS; k++) begin
      empty[k]      = (slot[k] == '0);
      hit_lookup[k] = (slot[k] == lookup_addr);
      hit_cmd[k]    = (slot[k] == cmd.addr);
    end
  end

  // A lookup may hit any slot up to and including the first empty one.
  // With no empty slot the mask below wraps to all ones.
  assign first_empty = empty & (~empty + HOST_SLOTS'(1));
  assign eligible    = (first_empty - HOST_SLOTS'(1)) | first_empty;

  assign free_or_hit = empty | hit_cmd;
  assign wr_sel      = free_or_hit & (~free_or_hit + HOST_SLOTS'(1));

  assign stat.known = |(hit_lookup & eligible);
  assign stat.added = cmd.add && (|wr_sel);

  always_ff @(posedge clk) begin
    if (rst || cmd.purge) begin
      for (int k = 0; k < HOST_SLOTS; k++) begin
        slot[k] <= '0;
      end
    end else if (cmd.add) begin
      for (int k = 0; k < HOST_SLOTS; k++) begin
        if (wr_sel[k]) begin
          slot[k] <= cmd.addr;
        end
      end
    end
  end

`ifndef SYNTH
  a_wr_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(wr_sel))
    else $error("host table selects more than one slot for insert");
  a_purge_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.purge |=> (slot[0] == '0))
    else $error("host table not cleared after purge");
  a_added_found: assert property (@(posedge clk) disable iff (rst)
    stat.added |=> (slot[0] != '0 || $past(cmd.addr) == '0))
    else $error("insert left the first slot empty");
`endif

endmodule

@@ hw/rtl/smb_flow_host_classifier_core.sv @@
// Top level of the SMB host classifier: input stage, classify logic, result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | input     | in_valid / in_stall   | req_type protocol src_addr dst_addr
//           |           |                       | src_port dst_port tcp_header_ok host_addr
//   out     | output    | out_valid / out_stall | is_smb
//
// Each transaction yields exactly one result, via the input and result registers.
// A new transaction may be accepted every cycle when not stalled; the host table update and
// lookup both happen in the single stage between the input and result registers.
// Reset clears the enable flag and the host table at once; no clearing pass is needed.
// A stalled result holds the result register, which in turn holds the input stage.
module smb_flow_host_classifier_core
  import smbhc_pkg::*;
#(
  parameter int HOST_SLOTS = HOST_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [PROTO_W-1:0] protocol,
  input  logic [ADDR_W-1:0]  src_addr,
  input  logic [ADDR_W-1:0]  dst_addr,
  input  logic [PORT_W-1:0]  src_port,
  input  logic [PORT_W-1:0]  dst_port,
  input  logic               tcp_header_ok,
  input  logic [ADDR_W-1:0]  host_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_smb
);

  logic               s_valid;
  req_t               s_req;
  logic [PROTO_W-1:0] s_protocol;
  logic [ADDR_W-1:0]  s_src_addr;
  logic [ADDR_W-1:0]  s_dst_addr;
  logic [PORT_W-1:0]  s_src_port;
  logic [PORT_W-1:0]  s_dst_port;
  logic               s_hdr_ok;
  logic [ADDR_W-1:0]  s_host_addr;
  logic               enabled;
  logic               enabled_next;

  logic               o_free;
  logic               s_fire;
  logic               is_classify;
  logic               is_set;
  logic [ADDR_W-1:0]  side_addr;
  logic [PORT_W-1:0]  side_port;
  logic               mark;
  tbl_cmd_t           cmd;
  tbl_stat_t          stat;

  assign o_free   = !out_valid || !out_stall;
  assign s_fire   = s_valid && o_free;
  assign in_stall = s_valid && !o_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_req       <= req_t'(req_type);
      s_protocol  <= protocol;
      s_src_addr  <= src_addr;
      s_dst_addr  <= dst_addr;
      s_src_port  <= src_port;
      s_dst_port  <= dst_port;
      s_hdr_ok    <= tcp_header_ok;
      s_host_addr <= host_addr;
    end
  end

  always_comb begin
    is_classify = 1'b0;
    is_set      = 1'b0;
    side_addr   = s_dst_addr;
    side_port   = s_dst_port;
    unique case (s_req)
      REQ_INBOUND: begin
        is_classify = 1'b1;
      end
      REQ_OUTBOUND: begin
        is_classify = 1'b1;
        side_addr   = s_src_addr;
        side_port   = s_src_port;
      end
      REQ_SET_HOST: begin
        is_set = 1'b1;
      end
      REQ_UNUSED: begin
        is_set = 1'b0;
      end
      default: begin
        is_set = 1'b0;
      end
    endcase
  end

  assign cmd.purge = s_fire && is_set && (s_host_addr == ADDR_ALL_ONES);
  assign cmd.add   = s_fire && is_set && (s_host_addr != ADDR_ALL_ONES);
  assign cmd.addr  = s_host_addr;

  smbhc_host_table #(
    .HOST_SLOTS(HOST_SLOTS)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .lookup_addr (side_addr),
    .stat        (stat)
  );

  assign mark = is_classify && enabled && (s_protocol == PROTO_TCP) && s_hdr_ok &&
                stat.known &&
                (side_port == SMB_PORT_DIRECT || side_port == SMB_PORT_NETBIOS);

  always_comb begin
    enabled_next = enabled;
    if (cmd.purge) begin
      enabled_next = 1'b0;
    end else if (stat.added) begin
      enabled_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else begin
      enabled <= enabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      is_smb <= mark;
    end
  end

`ifndef SYNTH
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !o_free) |=> s_valid)
    else $error("input stage dropped a stalled transaction");
  a_purge_disables: assert property (@(posedge clk) disable iff (rst)
    cmd.purge |=> !enabled)
    else $error("block still enabled after table purge");
  a_add_enables: assert property (@(posedge clk) disable iff (rst)
    stat.added |=> enabled)
    else $error("block not enabled after host insert");
  a_disabled_no_mark: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !enabled) |=> (out_valid && !is_smb))
    else $error("packet marked while block disabled");
  a_set_no_mark: assert property (@(posedge clk) disable iff (rst)
    (s_fire && is_set) |=> !is_smb)
    else $error("set-host transaction produced a mark");
`endif

endmodule
